[hdl/read_pair_log_likelihood_assert.svh]
// ----------------------------------------------------------------------------
// read pair log likelihood assertion macros
// shared concurrent checks, clocked on clock and disabled during reset
// ----------------------------------------------------------------------------
`ifndef READ_PAIR_LOG_LIKELIHOOD_ASSERT_SVH
`define READ_PAIR_LOG_LIKELIHOOD_ASSERT_SVH

// same-cycle implication
`define RPLL_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rpll same-cycle check failed");

// next-cycle implication
`define RPLL_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rpll next-cycle check failed");

`endif

[hdl/rpll_pkg.sv]
// ----------------------------------------------------------------------------
// rpll_pkg
// widths, constants, softplus correction table and saturation helpers
// ----------------------------------------------------------------------------
package rpll_pkg;

   localparam int FRAC_BITS              = 8;
   localparam int CORRECTION_TABLE_DEPTH = 256;
   localparam int MAX_MARKERS            = 1024;

   localparam int ALLELE_W = 4;
   localparam int LP_W     = 16;
   localparam int SUM_W    = 32;
   localparam int TOTAL_W  = 40;
   localparam int CNT_W    = $clog2(MAX_MARKERS + 1);

   localparam logic [ALLELE_W-1:0] NO_DATA = ALLELE_W'(9);

   localparam int CORR_W   = FRAC_BITS;
   localparam int IDX_W    = $clog2(CORRECTION_TABLE_DEPTH);
   localparam int DIFF_W   = SUM_W + 1;
   localparam int SCALE_W  = $clog2(CORRECTION_TABLE_DEPTH + 1);
   localparam int PROD_W   = DIFF_W + SCALE_W;
   localparam int IDX_SHIFT = FRAC_BITS + 4;
   localparam int LL_W     = SUM_W + 2;

   localparam longint Q30_ONE  = 64'sd1 << 30;
   localparam longint LN2_Q30  = 64'sd744261118;
   localparam longint EINV_Q30 = 64'sd395007542;

   localparam longint LOG_HALF_MAG =
      (LN2_Q30 + (64'sd1 << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);

   typedef logic [CORR_W-1:0] corr_table_type [CORRECTION_TABLE_DEPTH];

   // closed read handed from the accumulator to the close stage
   typedef struct packed {
      logic                    valid;
      logic                    last_read;
      logic signed [SUM_W-1:0] one;
      logic signed [SUM_W-1:0] two;
   } rpll_read_type;

   function automatic longint q30_round(input longint v);
      return (v + (64'sd1 << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
   endfunction

   // shift and subtract quotient of non-negative values, elaboration only
   function automatic longint udiv(input longint num, input longint den);
      logic [63:0] n;
      logic [63:0] d;
      logic [63:0] q;
      logic [64:0] r;
      n = num;
      d = den;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[63:0], n[b]};
         if (r >= {1'b0, d}) begin
            r = r - {1'b0, d};
            q[b] = 1'b1;
         end
      end
      return longint'(q);
   endfunction

   // ln(1 + exp(-x)) with x = 16*i/depth, elaboration only
   function automatic longint softplus_entry(input longint i);
      longint x;
      longint n;
      longint f;
      longint term;
      longint sum;
      longint y;
      longint z;
      longint z2;
      longint p;
      longint s;
      x = udiv(i <<< 34, longint'(CORRECTION_TABLE_DEPTH));
      n = x >>> 30;
      f = x & (Q30_ONE - 1);
      term = Q30_ONE;
      sum = Q30_ONE;
      for (int k = 1; k <= 24; k++) begin
         term = udiv((term * f) >>> 30, longint'(k));
         if ((k & 1) == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > Q30_ONE) begin
         sum = Q30_ONE;
      end
      y = sum;
      while (n > 0) begin
         y = (y * EINV_Q30) >>> 30;
         n = n - 1;
      end
      z = udiv(y <<< 30, 2 * Q30_ONE + y);
      z2 = (z * z) >>> 30;
      p = z;
      s = z;
      for (int k = 1; k <= 20; k++) begin
         p = (p * z2) >>> 30;
         s = s + udiv(p, longint'(2 * k + 1));
      end
      return q30_round(2 * s);
   endfunction

   function automatic corr_table_type build_corr_table();
      corr_table_type t;
      for (int i = 0; i < CORRECTION_TABLE_DEPTH; i++) begin
         t[i] = CORR_W'(softplus_entry(longint'(i)));
      end
      return t;
   endfunction

   localparam corr_table_type CORR_TABLE = build_corr_table();

   function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
      logic signed [SUM_W-1:0] r;
      if (v[SUM_W] != v[SUM_W-1]) begin
         r = v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         r = v[SUM_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [TOTAL_W-1:0] sat_total(
      input logic signed [TOTAL_W:0] v);
      logic signed [TOTAL_W-1:0] r;
      if (v[TOTAL_W] != v[TOTAL_W-1]) begin
         r = v[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}} : {1'b0, {(TOTAL_W-1){1'b1}}};
      end else begin
         r = v[TOTAL_W-1:0];
      end
      return r;
   endfunction

endpackage

[hdl/rpll_accum.sv]
// ----------------------------------------------------------------------------
// rpll_accum
// input word register and per-read haplotype sums with marker count
// ----------------------------------------------------------------------------
module rpll_accum (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [rpll_pkg::ALLELE_W-1:0]           req_observed_allele,
   input  logic [rpll_pkg::ALLELE_W-1:0]           req_hap_one_allele,
   input  logic [rpll_pkg::ALLELE_W-1:0]           req_hap_two_allele,
   input  logic signed [rpll_pkg::LP_W-1:0]        req_match_logprob,
   input  logic signed [rpll_pkg::LP_W-1:0]        req_mismatch_logprob,
   input  logic                                    req_last_marker,
   input  logic                                    req_last_read,
   output rpll_pkg::rpll_read_type                 closed,
   input  logic                                    close_ready
);

   `include "read_pair_log_likelihood_assert.svh"

   localparam int SUM_W = rpll_pkg::SUM_W;
   localparam int LP_W  = rpll_pkg::LP_W;
   localparam int CNT_W = rpll_pkg::CNT_W;

   logic                                 a_valid_ff, a_valid_in;
   logic [rpll_pkg::ALLELE_W-1:0]        ra_ff, h1_ff, h2_ff;
   logic signed [LP_W-1:0]               mlp_ff, xlp_ff;
   logic                                 last_marker_ff, last_read_ff;
   logic signed [SUM_W-1:0]              one_ff, one_in, two_ff, two_in;
   logic [CNT_W-1:0]                     cnt_ff, cnt_in;

   logic                                 a_close, a_fire, a_free, req_take;
   logic                                 count_ok, add_en;
   logic signed [LP_W-1:0]               one_lp, two_lp;
   logic signed [SUM_W-1:0]              one_new, two_new;

   assign a_close  = last_marker_ff | last_read_ff;
   assign a_fire   = a_valid_ff & (~a_close | close_ready);
   assign a_free   = ~a_valid_ff | a_fire;
   assign req_stall = ~a_free;
   assign req_take = req_valid & a_free;

   assign count_ok = cnt_ff < CNT_W'(rpll_pkg::MAX_MARKERS);
   assign add_en   = count_ok & (ra_ff != rpll_pkg::NO_DATA);
   assign one_lp   = (h1_ff == ra_ff) ? mlp_ff : xlp_ff;
   assign two_lp   = (h2_ff == ra_ff) ? mlp_ff : xlp_ff;

   always_comb begin
      one_new = one_ff;
      two_new = two_ff;
      if (add_en) begin
         one_new = rpll_pkg::sat_sum({one_ff[SUM_W-1], one_ff}
                   + {{(SUM_W+1-LP_W){one_lp[LP_W-1]}}, one_lp});
         two_new = rpll_pkg::sat_sum({two_ff[SUM_W-1], two_ff}
                   + {{(SUM_W+1-LP_W){two_lp[LP_W-1]}}, two_lp});
      end
   end

   assign closed.valid     = a_valid_ff & a_close;
   assign closed.last_read = last_read_ff;
   assign closed.one       = one_new;
   assign closed.two       = two_new;

   always_comb begin
      a_valid_in = a_valid_ff;
      one_in = one_ff;
      two_in = two_ff;
      cnt_in = cnt_ff;
      if (a_fire) begin
         a_valid_in = 1'b0;
         if (a_close) begin
            one_in = '0;
            two_in = '0;
            cnt_in = '0;
         end else begin
            one_in = one_new;
            two_in = two_new;
            cnt_in = count_ok ? cnt_ff + CNT_W'(1) : cnt_ff;
         end
      end
      if (req_take) begin
         a_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         one_ff     <= '0;
         two_ff     <= '0;
         cnt_ff     <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         one_ff     <= one_in;
         two_ff     <= two_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         ra_ff          <= req_observed_allele;
         h1_ff          <= req_hap_one_allele;
         h2_ff          <= req_hap_two_allele;
         mlp_ff         <= req_match_logprob;
         xlp_ff         <= req_mismatch_logprob;
         last_marker_ff <= req_last_marker;
         last_read_ff   <= req_last_read;
      end
   end

   `RPLL_ASSERT_NEXT(a_close_clears, a_fire && a_close,
      one_ff == '0 && two_ff == '0 && cnt_ff == '0)
   `RPLL_ASSERT_NOW(a_count_bound, 1'b1, cnt_ff <= CNT_W'(rpll_pkg::MAX_MARKERS))
   `RPLL_ASSERT_NEXT(a_blocked_holds, a_valid_ff && !a_fire,
      a_valid_ff && $stable(one_ff) && $stable(cnt_ff))

endmodule

[hdl/rpll_close.sv]
// ----------------------------------------------------------------------------
// rpll_close
// read close stage: log-sum-exp less ln 2 with softplus table, pair total, result word
// ----------------------------------------------------------------------------
module rpll_close (
   input  logic                                    clock,
   input  logic                                    reset,
   input  rpll_pkg::rpll_read_type                 closed,
   output logic                                    close_ready,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [rpll_pkg::TOTAL_W-1:0]     rsp_log_likelihood
);

   `include "read_pair_log_likelihood_assert.svh"

   localparam int SUM_W   = rpll_pkg::SUM_W;
   localparam int TOTAL_W = rpll_pkg::TOTAL_W;
   localparam int DIFF_W  = rpll_pkg::DIFF_W;
   localparam int PROD_W  = rpll_pkg::PROD_W;
   localparam int SCALE_W = rpll_pkg::SCALE_W;
   localparam int IDX_W   = rpll_pkg::IDX_W;
   localparam int CORR_W  = rpll_pkg::CORR_W;
   localparam int LL_W    = rpll_pkg::LL_W;

   logic                          b_valid_ff, b_valid_in;
   logic                          b_last_ff;
   logic signed [SUM_W-1:0]       b_one_ff, b_two_ff;
   logic signed [TOTAL_W-1:0]     total_ff, total_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [TOTAL_W-1:0]     rsp_data_ff;

   logic                          blocked, b_go, b_fire, b_load, b_emit;
   logic signed [SUM_W-1:0]       mx, mn;
   logic [DIFF_W-1:0]             diff;
   logic [PROD_W-1:0]             prod, idx_full;
   logic                          in_range;
   logic [CORR_W-1:0]             corr;
   logic signed [LL_W-1:0]        ll;
   logic signed [TOTAL_W-1:0]     total_new;

   assign blocked     = rsp_valid_ff & rsp_stall;
   assign b_go        = ~(b_last_ff & blocked);
   assign b_fire      = b_valid_ff & b_go;
   assign b_emit      = b_fire & b_last_ff;
   assign close_ready = ~b_valid_ff | b_go;
   assign b_load      = closed.valid & close_ready;

   assign mx   = (b_one_ff > b_two_ff) ? b_one_ff : b_two_ff;
   assign mn   = (b_one_ff > b_two_ff) ? b_two_ff : b_one_ff;
   assign diff = {mx[SUM_W-1], mx} - {mn[SUM_W-1], mn};
   assign prod = {{SCALE_W{1'b0}}, diff} * PROD_W'(rpll_pkg::CORRECTION_TABLE_DEPTH);
   assign idx_full = prod >> rpll_pkg::IDX_SHIFT;
   assign in_range = idx_full < PROD_W'(rpll_pkg::CORRECTION_TABLE_DEPTH);
   assign corr = in_range ? rpll_pkg::CORR_TABLE[idx_full[IDX_W-1:0]] : '0;

   assign ll = {{(LL_W-SUM_W){mx[SUM_W-1]}}, mx}
             + {{(LL_W-CORR_W){1'b0}}, corr}
             - LL_W'(rpll_pkg::LOG_HALF_MAG);
   assign total_new = rpll_pkg::sat_total({total_ff[TOTAL_W-1], total_ff}
                      + {{(TOTAL_W+1-LL_W){ll[LL_W-1]}}, ll});

   always_comb begin
      b_valid_in = b_valid_ff;
      if (b_fire) begin
         b_valid_in = 1'b0;
      end
      if (b_load) begin
         b_valid_in = 1'b1;
      end
   end

   always_comb begin
      total_in = total_ff;
      if (b_fire) begin
         total_in = b_last_ff ? '0 : total_new;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (b_emit) begin
         rsp_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_load) begin
         b_last_ff <= closed.last_read;
         b_one_ff  <= closed.one;
         b_two_ff  <= closed.two;
      end
      if (b_emit) begin
         rsp_data_ff <= total_new;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_log_likelihood = rsp_data_ff;

   `RPLL_ASSERT_NEXT(b_pair_end_clears, b_emit, total_ff == '0 && rsp_valid_ff)
   `RPLL_ASSERT_NOW(b_emit_needs_room, b_emit, !blocked)
   `RPLL_ASSERT_NEXT(b_stalled_holds, b_valid_ff && !b_go,
      b_valid_ff && b_last_ff && $stable(b_one_ff) && $stable(b_two_ff))

endmodule

[hdl/read_pair_log_likelihood.sv]
// a word with last_read set passes the input word register and the close stage register, then its result is registered
// throughput: one marker word per cycle while no closing word waits, set by the sum update loop
// a closing word waits only while the result register is full and stalled
// reset clears the read sums, marker count, pair total and all valid flags
// the softplus correction table is a constant and needs no fill after reset
// ----------------------------------------------------------------------------
// read_pair_log_likelihood
// accumulates per-read haplotype log likelihoods into a saturated pair total
// ----------------------------------------------------------------------------
module read_pair_log_likelihood (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [rpll_pkg::ALLELE_W-1:0]           req_observed_allele,
   input  logic [rpll_pkg::ALLELE_W-1:0]           req_hap_one_allele,
   input  logic [rpll_pkg::ALLELE_W-1:0]           req_hap_two_allele,
   input  logic signed [rpll_pkg::LP_W-1:0]        req_match_logprob,
   input  logic signed [rpll_pkg::LP_W-1:0]        req_mismatch_logprob,
   input  logic                                    req_last_marker,
   input  logic                                    req_last_read,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [rpll_pkg::TOTAL_W-1:0]     rsp_log_likelihood
);

   rpll_pkg::rpll_read_type closed;
   logic                    close_ready;

   rpll_accum u_accum (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_observed_allele  (req_observed_allele),
      .req_hap_one_allele   (req_hap_one_allele),
      .req_hap_two_allele   (req_hap_two_allele),
      .req_match_logprob    (req_match_logprob),
      .req_mismatch_logprob (req_mismatch_logprob),
      .req_last_marker      (req_last_marker),
      .req_last_read        (req_last_read),
      .closed               (closed),
      .close_ready          (close_ready)
   );

   rpll_close u_close (
      .clock              (clock),
      .reset              (reset),
      .closed             (closed),
      .close_ready        (close_ready),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_log_likelihood (rsp_log_likelihood)
   );

endmodule
